// ----- hw/rtl/lspe_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the LED strip pulse encoder.
package lspe_pkg;

    localparam int MODE_W   = 2;
    localparam int PIXEL_W  = 8;
    localparam int COLOR_W  = 24;
    localparam int LEVEL_W  = 8;
    localparam int INDEX_W  = 5;
    localparam int CODE_W   = 24;
    localparam int COUNT_W  = 6;

    localparam logic [COUNT_W-1:0] LED_COUNT_RESET = 6'd32;

    // pulse patterns for one data bit, sent MSB first
    localparam logic [2:0] CODE_ONE  = 3'b110;
    localparam logic [2:0] CODE_ZERO = 3'b100;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET_COLOUR = 2'd0,
        MODE_SET_LEVEL  = 2'd1,
        MODE_SHOW       = 2'd2,
        MODE_SET_ALL    = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHOW,
        ST_FILL
    } t_state;

    typedef struct packed {
        logic wr_colour;   // write colour of the addressed pixel
        logic wr_level;    // write brightness of the addressed pixel
        logic clr_idx;     // restart the pixel walk
        logic latch_fill;  // capture the colour for a set-all sweep
        logic fill_write;  // write fill colour at the walk index
        logic issue;       // issue a store read at the walk index
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;  // no pixels in use
        logic idx_last;    // walk index is the final pixel in use
        logic in_range;    // pixel field below the count in use
        logic pipe_en;     // output pipeline may advance
    } t_dp_status;

    // floor(p / 255) for p up to 255*255
    function automatic logic [7:0] div_full_scale(input logic [15:0] p);
        logic [16:0] t;
        t = 17'(p) + 17'(p[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [CODE_W-1:0] expand_byte(input logic [7:0] v);
        logic [CODE_W-1:0] code;
        for (int k = 0; k < 8; k++) begin
            code[3*k +: 3] = v[k] ? CODE_ONE : CODE_ZERO;
        end
        return code;
    endfunction

endpackage

// ----- hw/rtl/lspe_cmd_if.sv -----
`timescale 1ns / 1ps
// Command channel interface: one set or show command per transaction.
interface lspe_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [lspe_pkg::MODE_W-1:0]  mode;
    logic [lspe_pkg::PIXEL_W-1:0] pixel;
    logic [lspe_pkg::COLOR_W-1:0] color;
    logic [lspe_pkg::LEVEL_W-1:0] level;

    modport source (output valid, mode, pixel, color, level, input ready);
    modport sink   (input valid, mode, pixel, color, level, output ready);
endinterface

// ----- hw/rtl/lspe_res_if.sv -----
`timescale 1ns / 1ps
// Result channel interface: one encoded pixel per transaction.
interface lspe_res_if;
    logic                         valid;
    logic                         ready;
    logic [lspe_pkg::INDEX_W-1:0] pixel_index;
    logic [lspe_pkg::CODE_W-1:0]  green_code;
    logic [lspe_pkg::CODE_W-1:0]  red_code;
    logic [lspe_pkg::CODE_W-1:0]  blue_code;
    logic                         last;

    modport source (output valid, pixel_index, green_code, red_code, blue_code, last,
                    input ready);
    modport sink   (input valid, pixel_index, green_code, red_code, blue_code, last,
                    output ready);
endinterface

// ----- hw/rtl/lspe_cfg_if.sv -----
`timescale 1ns / 1ps
// Configuration write channel interface for the pixel count register.
interface lspe_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lspe_pkg::COUNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/lspe_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module lspe_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lspe_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine: command decode, show walk and set-all sweep.
module lspe_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [lspe_pkg::MODE_W-1:0] i_mode,
    input  lspe_pkg::t_dp_status        i_status,
    output logic                        o_ready,
    output lspe_pkg::t_dp_cmd           o_cmd
);

    lspe_pkg::t_state r_state;
    lspe_pkg::t_state n_state;
    lspe_pkg::t_mode  mode;
    logic             accept;

    assign mode   = lspe_pkg::t_mode'(i_mode);
    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lspe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lspe_pkg::ST_IDLE: begin
                if (accept && !i_status.count_zero) begin
                    case (mode)
                        lspe_pkg::MODE_SHOW:    n_state = lspe_pkg::ST_SHOW;
                        lspe_pkg::MODE_SET_ALL: n_state = lspe_pkg::ST_FILL;
                        default:                n_state = lspe_pkg::ST_IDLE;
                    endcase
                end
            end
            lspe_pkg::ST_SHOW: begin
                if (i_status.pipe_en && i_status.idx_last) begin
                    n_state = lspe_pkg::ST_IDLE;
                end
            end
            lspe_pkg::ST_FILL: begin
                if (i_status.idx_last) begin
                    n_state = lspe_pkg::ST_IDLE;
                end
            end
            default: n_state = lspe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            lspe_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    case (mode)
                        lspe_pkg::MODE_SET_COLOUR: o_cmd.wr_colour = i_status.in_range;
                        lspe_pkg::MODE_SET_LEVEL:  o_cmd.wr_level  = i_status.in_range;
                        lspe_pkg::MODE_SHOW:       o_cmd.clr_idx   = !i_status.count_zero;
                        lspe_pkg::MODE_SET_ALL: begin
                            o_cmd.clr_idx    = !i_status.count_zero;
                            o_cmd.latch_fill = !i_status.count_zero;
                        end
                        default: o_cmd = '0;
                    endcase
                end
            end
            lspe_pkg::ST_SHOW: o_cmd.issue      = i_status.pipe_en;
            lspe_pkg::ST_FILL: o_cmd.fill_write = 1'b1;
            default:           o_cmd            = '0;
        endcase
    end

    // an empty show or set-all leaves the controller idle
    a_empty_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.count_zero |=> r_state == lspe_pkg::ST_IDLE)
        else $error("empty command left idle");

    // sweep and show reads never overlap
    a_no_fill_and_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.fill_write && o_cmd.issue))
        else $error("fill write during show read");

    // the walk ends on the last pixel: leaving a sweep needs idx_last
    a_fill_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lspe_pkg::ST_FILL && !i_status.idx_last |=> r_state == lspe_pkg::ST_FILL)
        else $error("sweep ended early");

endmodule

// ----- hw/rtl/lspe_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: pixel stores, walk index, count register and scaling/encode pipeline.
module lspe_datapath #(
    parameter int PIXEL_DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lspe_pkg::t_dp_cmd              i_cmd,
    output lspe_pkg::t_dp_status           o_status,
    input  logic                           i_cfg_we,
    input  logic [lspe_pkg::COUNT_W-1:0]   i_cfg_data,
    input  logic [lspe_pkg::PIXEL_W-1:0]   i_pixel,
    input  logic [lspe_pkg::COLOR_W-1:0]   i_color,
    input  logic [lspe_pkg::LEVEL_W-1:0]   i_level,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [lspe_pkg::INDEX_W-1:0]   o_pixel_index,
    output logic [lspe_pkg::CODE_W-1:0]    o_green_code,
    output logic [lspe_pkg::CODE_W-1:0]    o_red_code,
    output logic [lspe_pkg::CODE_W-1:0]    o_blue_code,
    output logic                           o_last
);

    localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;
    localparam logic [6:0] DepthW = 7'(PIXEL_DEPTH);

    logic [lspe_pkg::COUNT_W-1:0] r_led_count;
    logic [6:0]                   in_use;
    logic [AW-1:0]                r_idx;
    logic [lspe_pkg::COLOR_W-1:0] r_fill;
    logic [PIXEL_DEPTH-1:0]       r_cv;
    logic [PIXEL_DEPTH-1:0]       r_bv;
    logic                         pipe_en;

    // store ports
    logic                         col_we;
    logic [AW-1:0]                col_waddr;
    logic [lspe_pkg::COLOR_W-1:0] col_wdata;
    logic [lspe_pkg::COLOR_W-1:0] col_rdata;
    logic [lspe_pkg::LEVEL_W-1:0] lvl_rdata;

    // stage 1: store read data
    logic          r_s1_v;
    logic [AW-1:0] r_s1_idx;
    logic          r_s1_last;
    logic          r_s1_cv;
    logic          r_s1_bv;

    // stage 2: products
    logic          r_s2_v;
    logic [AW-1:0] r_s2_idx;
    logic          r_s2_last;
    logic [15:0]   r_pg;
    logic [15:0]   r_pr;
    logic [15:0]   r_pb;

    // stage 3: output register
    logic                        r_o_v;
    logic [AW-1:0]               r_o_idx;
    logic                        r_o_last;
    logic [lspe_pkg::CODE_W-1:0] r_o_g;
    logic [lspe_pkg::CODE_W-1:0] r_o_r;
    logic [lspe_pkg::CODE_W-1:0] r_o_b;

    logic [lspe_pkg::COLOR_W-1:0] s1_colour;
    logic [lspe_pkg::LEVEL_W-1:0] s1_level;
    logic [7:0]                   o_idx_ext;
    logic [6:0]                   idx_ext;

    assign in_use  = ({1'b0, r_led_count} > DepthW) ? DepthW : {1'b0, r_led_count};
    assign idx_ext = 7'(r_idx);
    assign pipe_en = !r_o_v || i_ready;

    assign o_status.count_zero = (in_use == 7'd0);
    assign o_status.idx_last   = (idx_ext == in_use - 7'd1);
    assign o_status.in_range   = ({1'b0, in_use} > i_pixel);
    assign o_status.pipe_en    = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= lspe_pkg::LED_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_led_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.issue || i_cmd.fill_write) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.latch_fill) begin
            r_fill <= i_color;
        end
    end

    // entry valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= '0;
            r_bv <= '0;
        end else begin
            if (col_we) begin
                r_cv[col_waddr] <= 1'b1;
            end
            if (i_cmd.wr_level) begin
                r_bv[i_pixel[AW-1:0]] <= 1'b1;
            end
        end
    end

    assign col_we    = i_cmd.wr_colour || i_cmd.fill_write;
    assign col_waddr = i_cmd.fill_write ? r_idx : i_pixel[AW-1:0];
    assign col_wdata = i_cmd.fill_write ? r_fill : i_color;

    lspe_ram #(
        .WIDTH (lspe_pkg::COLOR_W),
        .DEPTH (PIXEL_DEPTH)
    ) u_colour_ram (
        .i_clk   (i_clk),
        .i_we    (col_we),
        .i_waddr (col_waddr),
        .i_wdata (col_wdata),
        .i_re    (i_cmd.issue),
        .i_raddr (r_idx),
        .o_rdata (col_rdata)
    );

    lspe_ram #(
        .WIDTH (lspe_pkg::LEVEL_W),
        .DEPTH (PIXEL_DEPTH)
    ) u_level_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_level),
        .i_waddr (i_pixel[AW-1:0]),
        .i_wdata (i_level),
        .i_re    (i_cmd.issue),
        .i_raddr (r_idx),
        .o_rdata (lvl_rdata)
    );

    // whole pipeline advances together; RAM read data holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else if (pipe_en) begin
            r_s1_v <= i_cmd.issue;
            r_s2_v <= r_s1_v;
            r_o_v  <= r_s2_v;
        end
    end

    assign s1_colour = r_s1_cv ? col_rdata : '0;
    assign s1_level  = r_s1_bv ? lvl_rdata : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_s1_idx  <= r_idx;
            r_s1_last <= o_status.idx_last;
            r_s1_cv   <= r_cv[r_idx];
            r_s1_bv   <= r_bv[r_idx];
        end
        if (pipe_en) begin
            r_s2_idx  <= r_s1_idx;
            r_s2_last <= r_s1_last;
            r_pg      <= s1_colour[15:8]  * s1_level;
            r_pr      <= s1_colour[23:16] * s1_level;
            r_pb      <= s1_colour[7:0]   * s1_level;
            r_o_idx   <= r_s2_idx;
            r_o_last  <= r_s2_last;
            r_o_g     <= lspe_pkg::expand_byte(lspe_pkg::div_full_scale(r_pg));
            r_o_r     <= lspe_pkg::expand_byte(lspe_pkg::div_full_scale(r_pr));
            r_o_b     <= lspe_pkg::expand_byte(lspe_pkg::div_full_scale(r_pb));
        end
    end

    assign o_idx_ext     = 8'(r_o_idx);
    assign o_valid       = r_o_v;
    assign o_pixel_index = o_idx_ext[lspe_pkg::INDEX_W-1:0];
    assign o_green_code  = r_o_g;
    assign o_red_code    = r_o_r;
    assign o_blue_code   = r_o_b;
    assign o_last        = r_o_last;

    // reads stay inside the pixels in use
    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.issue |-> idx_ext < in_use)
        else $error("store read beyond pixels in use");

    // a stalled read result is not dropped
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !pipe_en |=> r_s1_v)
        else $error("stage one lost on stall");

    // set-all sweep never runs past the count
    a_fill_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_write |-> idx_ext < in_use)
        else $error("fill write beyond pixels in use");

endmodule

// ----- hw/rtl/led_strip_spi_pulse_encoder.sv -----
`timescale 1ns / 1ps
// Top level: pixel store and pulse encoder for an SPI-driven LED strip.
//
//  channel  dir  modport  transaction
//  i_cmd    in   sink     mode, pixel, color, level
//  o_res    out  source   pixel_index, green/red/blue_code, last
//  i_cfg    in   sink     led_count (always ready)
//
// Set all sweeps the colour RAM, one pixel a cycle, and holds i_cmd.ready low
// until every pixel in use is written. Show issues one RAM read a cycle while o_res
// keeps up and busies i_cmd until the last pixel in use is read; results leave a
// three-stage read/multiply/encode pipeline.
// Reset clears per-pixel valid bits at once, no clearing pass; stalls on o_res
// freeze the whole show pipeline and stretch the show by the stalled cycles.
module led_strip_spi_pulse_encoder #(
    parameter int PIXEL_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lspe_cmd_if.sink    i_cmd,
    lspe_res_if.source  o_res,
    lspe_cfg_if.sink    i_cfg
);

    lspe_pkg::t_dp_cmd    cmd;
    lspe_pkg::t_dp_status status;
    logic                 cmd_ready;

    assign i_cmd.ready = cmd_ready;
    assign i_cfg.ready = 1'b1;

    lspe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_cmd.valid),
        .i_mode   (i_cmd.mode),
        .i_status (status),
        .o_ready  (cmd_ready),
        .o_cmd    (cmd)
    );

    lspe_datapath #(
        .PIXEL_DEPTH (PIXEL_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg.valid && i_cfg.ready),
        .i_cfg_data    (i_cfg.data),
        .i_pixel       (i_cmd.pixel),
        .i_color       (i_cmd.color),
        .i_level       (i_cmd.level),
        .o_valid       (o_res.valid),
        .i_ready       (o_res.ready),
        .o_pixel_index (o_res.pixel_index),
        .o_green_code  (o_res.green_code),
        .o_red_code    (o_res.red_code),
        .o_blue_code   (o_res.blue_code),
        .o_last        (o_res.last)
    );

endmodule

// ----- bench/led_strip_spi_pulse_encoder_tb.sv -----
`timescale 1ns / 1ps
// Testbench for the LED strip pulse encoder: directed and random commands, predictor check.
module led_strip_spi_pulse_encoder_tb;

    localparam int          NUM_PIXELS   = 32;
    localparam int          SETTLE_CYC   = 48;     // set-all sweep plus pipeline
    localparam int          LONG_HOLD    = 400;
    localparam int          PHASE_ITEMS  = 50;
    localparam int          NUM_PHASES   = 7;
    localparam int unsigned CYCLE_LIMIT  = 3_000_000;
    localparam logic [23:0] DARK_CODE    = 24'h924924;   // byte 0 after expansion

    typedef struct packed {
        lspe_pkg::t_mode mode;
        logic [7:0]      pixel;
        logic [23:0]     color;
        logic [7:0]      level;
    } t_strip_cmd;

    typedef struct packed {
        t_strip_cmd   cmd;
        logic         typed;     // expected codes given in the row
        logic [23:0]  code;
    } t_cmd_row;

    typedef struct packed {
        logic [lspe_pkg::INDEX_W-1:0] index;
        logic [lspe_pkg::CODE_W-1:0]  green;
        logic [lspe_pkg::CODE_W-1:0]  red;
        logic [lspe_pkg::CODE_W-1:0]  blue;
        logic                         last;
    } t_pixel_code;

    logic i_clk;
    logic i_rst_n;

    lspe_cmd_if cmd_ch();
    lspe_res_if res_ch();
    lspe_cfg_if cfg_ch();

    led_strip_spi_pulse_encoder #(.PIXEL_DEPTH(NUM_PIXELS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow of the block's state
    logic [23:0]                  colour_mem [NUM_PIXELS];
    logic [7:0]                   level_mem  [NUM_PIXELS];
    logic [lspe_pkg::COUNT_W-1:0] strip_len;

    t_pixel_code pending_codes [$];
    int          errors = 0;
    bit          calm;
    bit          long_hold_req;

    t_cmd_row dir_rows [19] = '{
        '{'{lspe_pkg::MODE_SHOW,       8'd0,   24'h000000, 8'd0},   1'b1, DARK_CODE},
        '{'{lspe_pkg::MODE_SET_ALL,    8'd0,   24'hFFFFFF, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SHOW,       8'd0,   24'h000000, 8'd0},   1'b1, DARK_CODE},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd0,   24'h000000, 8'd255}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd31,  24'h000000, 8'd255}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd32,  24'h000000, 8'd255}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd255, 24'h000000, 8'd200}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd0,   24'hFFFFFF, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd31,  24'h000000, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd255, 24'h123456, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd1,   24'hABCDEF, 8'd128}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd1,   24'hFF8001, 8'd77},  1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd2,   24'hA5005A, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd2,   24'h000000, 8'd1},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_LEVEL,  8'd3,   24'h000000, 8'd254}, 1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_COLOUR, 8'd3,   24'h7F80FE, 8'd0},   1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SHOW,       8'd200, 24'h5A5A5A, 8'd99},  1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SET_ALL,    8'd77,  24'h00FF00, 8'd33},  1'b0, 24'h0},
        '{'{lspe_pkg::MODE_SHOW,       8'd0,   24'h000000, 8'd0},   1'b0, 24'h0}
    };

    logic [lspe_pkg::COUNT_W-1:0] phase_len [NUM_PHASES] =
        '{6'd0, 6'd1, 6'd63, 6'd33, 6'd2, 6'd9, 6'd32};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pixels_active();
        return (strip_len > NUM_PIXELS) ? NUM_PIXELS : int'(strip_len);
    endfunction

    function automatic logic [7:0] dim_byte(input logic [7:0] c, input logic [7:0] lv);
        int unsigned prod;
        prod = c * lv;
        return 8'(prod / 255);
    endfunction

    // MSB first, three pulse bits per data bit
    function automatic logic [23:0] pulse_code(input logic [7:0] v);
        logic [23:0] code;
        code = '0;
        for (int k = 7; k >= 0; k--) begin
            code = {code[20:0], v[k] ? lspe_pkg::CODE_ONE : lspe_pkg::CODE_ZERO};
        end
        return code;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic update_strip(input t_strip_cmd c, input logic typed, input logic [23:0] code);
        int          n;
        t_pixel_code pc;
        n = pixels_active();
        case (c.mode)
            lspe_pkg::MODE_SET_COLOUR: begin
                if (c.pixel < n) colour_mem[c.pixel] = c.color;
            end
            lspe_pkg::MODE_SET_LEVEL: begin
                if (c.pixel < n) level_mem[c.pixel] = c.level;
            end
            lspe_pkg::MODE_SET_ALL: begin
                for (int i = 0; i < n; i++) colour_mem[i] = c.color;
            end
            default: begin
                for (int i = 0; i < n; i++) begin
                    pc.index = i[lspe_pkg::INDEX_W-1:0];
                    pc.green = pulse_code(dim_byte(colour_mem[i][15:8], level_mem[i]));
                    pc.red   = pulse_code(dim_byte(colour_mem[i][23:16], level_mem[i]));
                    pc.blue  = pulse_code(dim_byte(colour_mem[i][7:0], level_mem[i]));
                    pc.last  = (i == n - 1);
                    if (typed) begin
                        pc.green = code;
                        pc.red   = code;
                        pc.blue  = code;
                    end
                    pending_codes.push_back(pc);
                end
            end
        endcase
    endtask

    task automatic send_cmd(input t_strip_cmd c, input logic typed, input logic [23:0] code);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cmd_ch.valid <= 1'b1;
        cmd_ch.mode  <= c.mode;
        cmd_ch.pixel <= c.pixel;
        cmd_ch.color <= c.color;
        cmd_ch.level <= c.level;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        update_strip(c, typed, code);
    endtask

    task automatic write_len(input logic [lspe_pkg::COUNT_W-1:0] v);
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        strip_len = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_strip_cmd random_cmd();
        t_strip_cmd c;
        int         r;
        int         n;
        n = pixels_active();
        r = $urandom_range(0, 99);
        if (r < 38)      c.mode = lspe_pkg::MODE_SET_COLOUR;
        else if (r < 76) c.mode = lspe_pkg::MODE_SET_LEVEL;
        else if (r < 88) c.mode = lspe_pkg::MODE_SHOW;
        else             c.mode = lspe_pkg::MODE_SET_ALL;
        if (n > 0 && $urandom_range(0, 99) < 85) c.pixel = 8'($urandom_range(0, n - 1));
        else                                     c.pixel = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 19);
        c.color = (r == 0) ? 24'h000000 : (r == 1) ? 24'hFFFFFF : 24'($urandom);
        r = $urandom_range(0, 9);
        c.level = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // result side: random stalls, one long hold on request
    initial begin
        int          stall_left;
        bit          hold_done;
        t_pixel_code e;
        stall_left   = 0;
        hold_done    = 1'b0;
        res_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                res_ch.ready <= 1'b1;
            end
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready) begin
                if (pending_codes.size() == 0) begin
                    $display("%0t: unexpected result, pixel %0d", $time, res_ch.pixel_index);
                    errors++;
                end else begin
                    e = pending_codes.pop_front();
                    check_field("pixel_index", 24'(e.index), 24'(res_ch.pixel_index));
                    check_field("green_code", e.green, res_ch.green_code);
                    check_field("red_code", e.red, res_ch.red_code);
                    check_field("blue_code", e.blue, res_ch.blue_code);
                    check_field("last", 24'(e.last), 24'(res_ch.last));
                end
                stall_left = pick_gap();
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("%0t: timeout, %0d results outstanding", $time, pending_codes.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        calm          = 1'b0;
        long_hold_req = 1'b0;
        strip_len     = lspe_pkg::LED_COUNT_RESET;
        for (int i = 0; i < NUM_PIXELS; i++) begin
            colour_mem[i] = '0;
            level_mem[i]  = '0;
        end
        i_rst_n      = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.mode  = lspe_pkg::MODE_SET_COLOUR;
        cmd_ch.pixel = '0;
        cmd_ch.color = '0;
        cmd_ch.level = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].code);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_len((p == 5) ? 6'($urandom_range(3, 31)) : phase_len[p]);
            calm = (p == 4);
            if (p == 2) long_hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_cmd(random_cmd(), 1'b0, 24'h0);
        end

        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (pending_codes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
